FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SIRF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define SIRF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: sv/sirf_pkg.sv
// ----------------------------------------------------------------------------
// sirf_pkg
// Function codes, orientation layout, sequencer states and store control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sirf_pkg;

  localparam int FUNC_W = 3;
  localparam int ROW_W  = 4;
  localparam int COL_W  = 4;
  localparam int PIN_W  = 8;
  localparam int POUT_W = 8;

  localparam logic [FUNC_W-1:0] FUNC_WRITE    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_ROT_CW   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_ROT_CCW  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_FLIP_ROW = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_FLIP_COL = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_READ     = 3'd5;

  // bit 0 swaps row and column, bit 1 mirrors the row, bit 2 the column
  typedef struct packed {
    logic mcol;
    logic mrow;
    logic swap;
  } orient_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MROW  = 5'b00010,
    S_MCOL  = 5'b00100,
    S_MEM   = 5'b01000,
    S_RDATA = 5'b10000
  } state_t;

  typedef struct packed {
    logic wr;
    logic rd;
  } store_ctl_t;

endpackage

`default_nettype wire

FILE: sv/sirf_store.sv
// ----------------------------------------------------------------------------
// sirf_store
// Single-port pixel store with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sirf_store
  import sirf_pkg::*;
#(
  parameter int DEPTH  = 256,
  parameter int DATA_W = 8
) (
  input  wire logic                     clk,
  input  wire store_ctl_t               ctl,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [DATA_W-1:0]        wdata,
  output logic      [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/square_image_rotate_flip.sv
// ----------------------------------------------------------------------------
// square_image_rotate_flip
// SIDE x SIDE pixel store with rotations and flips kept as an orientation.
// ----------------------------------------------------------------------------
// Input stream s_axis: one word per command. tuser carries the function
// (write, rotate clockwise, rotate counter-clockwise, flip rows, flip
// columns, read); tdata carries row, column and the pixel to write.
// Output stream m_axis: one word per read, holding the pixel.
// Transforms only update a 3-bit orientation.
// Writes and reads remap the address through one shared mirror subtractor,
// a row step then a column step, then access the single-port store;
// a read then loads its pixel into the output register from S_RDATA,
// which raises m_axis_tvalid.
// s_axis_tready is high only while the sequencer is idle.
// A finished read sits in the output register; if the receiver stalls
// while a second read completes, the sequencer holds until it is taken.
// Reset clears the orientation to identity and empties the output
// register; pixel contents are undefined until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module square_image_rotate_flip
  import sirf_pkg::*;
#(
  parameter int SIDE       = 16,
  parameter int PIXEL_BITS = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [15:0]       s_axis_tdata,  // row[3:0], col[7:4], pixel_in[15:8]
  input  wire logic [FUNC_W-1:0] s_axis_tuser,  // func[2:0]
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [POUT_W-1:0]      m_axis_tdata   // pixel_out[7:0]
);

  localparam int IDX_W  = $clog2(SIDE);
  localparam int CMP_W  = (IDX_W + 1 > ROW_W) ? IDX_W + 1 : ROW_W;
  localparam int DEPTH  = SIDE * SIDE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PROD_W = 2 * IDX_W;
  localparam int PX_W   = (PIXEL_BITS > PIN_W) ? PIXEL_BITS : PIN_W;

  state_t                  state, state_next;
  orient_t                 orientation, orientation_next;
  logic                    op_read;
  logic                    in_range;
  logic [IDX_W-1:0]        a, b;
  logic [PIXEL_BITS-1:0]   pix;
  logic                    out_valid, out_valid_next;
  logic [POUT_W-1:0]       out_data;

  logic                    in_accept;
  logic [FUNC_W-1:0]       func;
  logic [CMP_W-1:0]        row_x, col_x;
  logic [PX_W-1:0]         pin_x, rdata_x;
  logic                    range_ok;
  logic [IDX_W-1:0]        unit_in, unit_out;
  logic [PROD_W-1:0]       addr_prod;
  logic [ADDR_W-1:0]       addr;
  logic [PIXEL_BITS-1:0]   rdata;
  store_ctl_t              ctl;
  logic                    load_out;

  assign s_axis_tready = (state == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign func          = s_axis_tuser;
  assign row_x         = CMP_W'(s_axis_tdata[3:0]);
  assign col_x         = CMP_W'(s_axis_tdata[7:4]);
  assign pin_x         = PX_W'(s_axis_tdata[15:8]);
  assign range_ok      = (row_x < CMP_W'(SIDE)) && (col_x < CMP_W'(SIDE));

  // shared mirror unit
  assign unit_in  = (state == S_MROW) ? a : b;
  assign unit_out = IDX_W'(SIDE - 1) - unit_in;

  assign addr_prod = PROD_W'(a) * PROD_W'(SIDE) + PROD_W'(b);
  assign addr      = addr_prod[ADDR_W-1:0];

  assign ctl.wr = (state == S_MEM) && !op_read && in_range;
  assign ctl.rd = (state == S_MEM) && op_read;

  sirf_store #(
    .DEPTH  (DEPTH),
    .DATA_W (PIXEL_BITS)
  ) u_store (
    .clk   (clk),
    .ctl   (ctl),
    .addr  (addr),
    .wdata (pix),
    .rdata (rdata)
  );

  assign rdata_x  = PX_W'(rdata);
  assign load_out = (state == S_RDATA) && (!out_valid || m_axis_tready);

  always_comb begin
    state_next       = state;
    orientation_next = orientation;
    out_valid_next   = out_valid;
    if (out_valid && m_axis_tready) begin
      out_valid_next = 1'b0;
    end
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          case (func)
            FUNC_WRITE, FUNC_READ: begin
              state_next = S_MROW;
            end
            FUNC_ROT_CW: begin
              if (orientation.swap) orientation_next.mcol = ~orientation.mcol;
              else                  orientation_next.mrow = ~orientation.mrow;
              orientation_next.swap = ~orientation.swap;
            end
            FUNC_ROT_CCW: begin
              if (orientation.swap) orientation_next.mrow = ~orientation.mrow;
              else                  orientation_next.mcol = ~orientation.mcol;
              orientation_next.swap = ~orientation.swap;
            end
            FUNC_FLIP_ROW: begin
              if (orientation.swap) orientation_next.mcol = ~orientation.mcol;
              else                  orientation_next.mrow = ~orientation.mrow;
            end
            FUNC_FLIP_COL: begin
              if (orientation.swap) orientation_next.mrow = ~orientation.mrow;
              else                  orientation_next.mcol = ~orientation.mcol;
            end
            default: begin
            end
          endcase
        end
      end
      S_MROW:  state_next = S_MCOL;
      S_MCOL:  state_next = S_MEM;
      S_MEM:   state_next = op_read ? S_RDATA : S_IDLE;
      S_RDATA: begin
        if (load_out) begin
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      orientation <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      orientation <= orientation_next;
      out_valid   <= out_valid_next;
    end
  end

  // payload: swap at accept, then mirror one index per step
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_read  <= (func == FUNC_READ);
      in_range <= range_ok;
      pix      <= pin_x[PIXEL_BITS-1:0];
      a        <= orientation.swap ? col_x[IDX_W-1:0] : row_x[IDX_W-1:0];
      b        <= orientation.swap ? row_x[IDX_W-1:0] : col_x[IDX_W-1:0];
    end
    if ((state == S_MROW) && orientation.mrow) begin
      a <= unit_out;
    end
    if ((state == S_MCOL) && orientation.mcol) begin
      b <= unit_out;
    end
    if (load_out) begin
      out_data <= in_range ? rdata_x[POUT_W-1:0] : '0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  `SIRF_ASSERT_NXT(a_accept_no_result, in_accept && !m_axis_tvalid, !m_axis_tvalid)
  `SIRF_ASSERT_IMP(a_result_from_read, $rose(m_axis_tvalid), $past(state == S_RDATA))
  `SIRF_ASSERT_IMP(a_orient_on_accept, orientation != $past(orientation), $past(in_accept))

endmodule

`default_nettype wire

FILE: dv/square_image_rotate_flip_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// square_image_rotate_flip_test
// Self-checking bench for the square picture store with rotations and flips.
// A directed burst covers the corner pixels, every transform and the spare
// function codes. Random command streams then run under three idle mixes
// on the two streams, and one long receiver hold-off stalls the input.
// Every read is checked against a local model of the orientation and store.
// ----------------------------------------------------------------------------
module square_image_rotate_flip_test;
  import sirf_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_SPARE_A = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_B = 3'd7;
  localparam int SIDE_LEN   = 16;
  localparam int STALL_LIM  = 3000;
  localparam int HOLD_LEN   = 400;
  localparam int RUN_ITEMS  = 530;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata = '0;   // row[3:0], col[7:4], pixel_in[15:8]
  logic [FUNC_W-1:0] s_axis_tuser = '0;   // func[2:0]
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [POUT_W-1:0] m_axis_tdata;        // pixel_out[7:0]

  // picture model: orientation plus physical store with written marks
  orient_t           orient;
  logic [PIN_W-1:0]  picture [SIDE_LEN*SIDE_LEN];
  bit                painted [SIDE_LEN*SIDE_LEN];
  logic [POUT_W-1:0] pixels_due [$];
  logic [POUT_W-1:0] pixel_want;

  int src_idle_pct = 0;
  int rx_idle_pct  = 0;
  bit rx_hold      = 1'b0;
  int mismatches   = 0;
  int idle_cycles  = 0;
  int reads_done   = 0;
  int writes_done  = 0;
  int turns_done   = 0;
  int spares_done  = 0;

  square_image_rotate_flip dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic logic [7:0] phys_index(input logic [3:0] row, input logic [3:0] col);
    logic [3:0] a;
    logic [3:0] b;
    a = orient.swap ? col : row;
    b = orient.swap ? row : col;
    if (orient.mrow) a = 4'(SIDE_LEN - 1) - a;
    if (orient.mcol) b = 4'(SIDE_LEN - 1) - b;
    return {a, b};
  endfunction

  // advance the picture model by one accepted word
  task automatic apply_word(input logic [FUNC_W-1:0] func, input logic [3:0] row,
                            input logic [3:0] col, input logic [PIN_W-1:0] pix);
    logic [7:0] addr;
    addr = phys_index(row, col);
    case (func)
      FUNC_WRITE: begin
        picture[addr] = pix;
        painted[addr] = 1'b1;
        writes_done++;
      end
      FUNC_ROT_CW: begin
        if (orient.swap) orient.mcol = ~orient.mcol;
        else orient.mrow = ~orient.mrow;
        orient.swap = ~orient.swap;
        turns_done++;
      end
      FUNC_ROT_CCW: begin
        if (orient.swap) orient.mrow = ~orient.mrow;
        else orient.mcol = ~orient.mcol;
        orient.swap = ~orient.swap;
        turns_done++;
      end
      FUNC_FLIP_ROW: begin
        if (orient.swap) orient.mcol = ~orient.mcol;
        else orient.mrow = ~orient.mrow;
        turns_done++;
      end
      FUNC_FLIP_COL: begin
        if (orient.swap) orient.mrow = ~orient.mrow;
        else orient.mcol = ~orient.mcol;
        turns_done++;
      end
      FUNC_READ: begin
        pixels_due.push_back(picture[addr]);
        reads_done++;
      end
      default: spares_done++;
    endcase
  endtask

  task automatic send_word(input logic [FUNC_W-1:0] func, input logic [3:0] row,
                           input logic [3:0] col, input logic [PIN_W-1:0] pix);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pix, col, row};
    s_axis_tuser  <= func;
    do @(posedge clk); while (!s_axis_tready);
    apply_word(func, row, col, pix);
  endtask

  // a read of an unwritten pixel becomes a write there instead
  task automatic send_random_word();
    logic [FUNC_W-1:0] func;
    logic [3:0]        row;
    logic [3:0]        col;
    logic [PIN_W-1:0]  pix;
    int                pick;
    pick = $urandom_range(0, 99);
    row  = 4'($urandom);
    col  = 4'($urandom);
    pix  = 8'($urandom);
    if (pick < 45) func = FUNC_READ;
    else if (pick < 70) func = FUNC_WRITE;
    else if (pick < 95) func = 3'($urandom_range(FUNC_ROT_CW, FUNC_FLIP_COL));
    else func = ($urandom_range(0, 1) != 0) ? FUNC_SPARE_A : FUNC_SPARE_B;
    if (func == FUNC_READ && !painted[phys_index(row, col)]) func = FUNC_WRITE;
    send_word(func, row, col, pix);
  endtask

  task automatic test_directed();
    send_word(FUNC_WRITE, 4'd0, 4'd0, 8'h00);
    send_word(FUNC_WRITE, 4'd0, 4'd15, 8'hFF);
    send_word(FUNC_WRITE, 4'd15, 4'd0, 8'hA5);
    send_word(FUNC_WRITE, 4'd15, 4'd15, 8'h5A);
    send_word(FUNC_READ, 4'd0, 4'd0, 8'h00);
    send_word(FUNC_READ, 4'd0, 4'd15, 8'h00);
    send_word(FUNC_READ, 4'd15, 4'd0, 8'h00);
    send_word(FUNC_READ, 4'd15, 4'd15, 8'h00);
    send_word(FUNC_ROT_CW, 4'd0, 4'd0, 8'h00);
    send_word(FUNC_READ, 4'd0, 4'd0, 8'h00);
    send_word(FUNC_ROT_CCW, 4'd0, 4'd0, 8'h00);
    send_word(FUNC_READ, 4'd0, 4'd15, 8'h00);
    send_word(FUNC_FLIP_ROW, 4'd0, 4'd0, 8'h00);
    send_word(FUNC_READ, 4'd15, 4'd0, 8'h00);
    send_word(FUNC_FLIP_COL, 4'd0, 4'd0, 8'h00);
    send_word(FUNC_READ, 4'd15, 4'd15, 8'h00);
    send_word(FUNC_SPARE_A, 4'd3, 4'd3, 8'hC3);
    send_word(FUNC_SPARE_B, 4'd0, 4'd0, 8'h3C);
    send_word(FUNC_ROT_CW, 4'd0, 4'd0, 8'h00);
    send_word(FUNC_ROT_CW, 4'd0, 4'd0, 8'h00);
    send_word(FUNC_READ, 4'd0, 4'd0, 8'h00);
    send_word(FUNC_WRITE, 4'd7, 4'd9, 8'h3C);
    send_word(FUNC_READ, 4'd7, 4'd9, 8'h00);
    send_word(FUNC_READ, 4'd0, 4'd15, 8'h00);
  endtask

  task automatic test_random(input int items, input int src_pct, input int rx_pct);
    int target;
    src_idle_pct = src_pct;
    rx_idle_pct  = rx_pct;
    target = reads_done + writes_done + turns_done + items;
    while (reads_done + writes_done + turns_done < target) send_random_word();
  endtask

  // hold the receiver off so finished reads pile up and block the input
  task automatic test_output_stall();
    src_idle_pct = 0;
    rx_idle_pct  = 0;
    fork
      begin
        rx_hold = 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        rx_hold = 1'b0;
      end
      for (int i = 0; i < 24; i++) begin
        send_word(FUNC_READ, (i % 2 != 0) ? 4'd15 : 4'd0, (i % 4 > 1) ? 4'd15 : 4'd0, 8'h00);
      end
    join
  endtask

  always @(posedge clk) begin
    m_axis_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pixels_due.size() == 0) begin
        report_mismatch($sformatf("pixel %02h with no read pending", m_axis_tdata));
      end else begin
        pixel_want = pixels_due.pop_front();
        if (m_axis_tdata !== pixel_want)
          report_mismatch($sformatf("pixel_out %02h, want %02h", m_axis_tdata, pixel_want));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIM) begin
        $display("watchdog: no word moved for %0d cycles", STALL_LIM);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    orient = '0;
    foreach (painted[i]) painted[i] = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(RUN_ITEMS, 38, 62);
    test_output_stall();
    test_random(RUN_ITEMS, 62, 38);
    test_random(RUN_ITEMS, 0, 0);
    s_axis_tvalid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pixels_due.size() != 0) report_mismatch("reads left without a result");
    $display("covered %0d reads, %0d writes, %0d transforms, %0d spare codes",
             reads_done, writes_done, turns_done, spares_done);
    $display("idle mixes 38/62, 62/38, 0/0 and one %0d-cycle output hold-off", HOLD_LEN);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/sirf_pkg.sv
sv/sirf_store.sv
sv/square_image_rotate_flip.sv
dv/square_image_rotate_flip_test.sv
